FILE: rtl/tip_pkg.sv
// Package for the telnet IAC stream parser: byte codes, parse states, token kinds.
// Holds the payload structs of the top level and the classifier decision struct shared with it.
// No dependencies.
package tip_pkg;

	// Telnet protocol bytes.
	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_CR   = 8'd13;
	localparam logic [7:0] B_NUL  = 8'd0;

	// Token kinds.
	localparam logic [2:0] KIND_TEXT    = 3'd0;
	localparam logic [2:0] KIND_CMD     = 3'd1;
	localparam logic [2:0] KIND_SUBBYTE = 3'd2;
	localparam logic [2:0] KIND_SUBEND  = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;

	// Per-direction parse state, one-hot.
	typedef enum logic [5:0] {
		ST_NORMAL = 6'b000001,
		ST_CR     = 6'b000010,
		ST_IAC    = 6'b000100,
		ST_OPT    = 6'b001000,
		ST_SUB1   = 6'b010000,
		ST_SUB2   = 6'b100000
	} state_t;

	// One input word.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       direction;
		logic       last_of_chunk;
	} byte_t;

	// One result word.
	typedef struct packed {
		logic       token_valid;
		logic [2:0] token_kind;
		logic [7:0] token_value;
		logic       direction_out;
		logic       chunk_end;
	} tok_t;

	// Classifier decision for one byte.
	typedef struct packed {
		state_t     next_state;
		logic       tok_valid;
		logic [2:0] kind;
		logic [7:0] value;
	} cls_t;

endpackage

FILE: rtl/tip_classify.sv
// Next-state and token function of the telnet parser for one byte.
// Purely combinational; depends on tip_pkg.
module tip_classify (
	input  tip_pkg::state_t   state,
	input  logic [7:0]        data_byte,
	output tip_pkg::cls_t     cls
);

	always_comb begin
		cls.next_state = tip_pkg::ST_NORMAL;
		cls.tok_valid  = 1'b0;
		cls.kind       = tip_pkg::KIND_TEXT;
		cls.value      = 8'd0;
		unique case (state)
			tip_pkg::ST_CR: begin
				if (data_byte == tip_pkg::B_NUL) begin
					cls.next_state = tip_pkg::ST_NORMAL;
				end else if (data_byte == tip_pkg::B_IAC) begin
					cls.next_state = tip_pkg::ST_IAC;
				end else begin
					cls.tok_valid  = 1'b1;
					cls.value      = data_byte;
					cls.next_state = (data_byte == tip_pkg::B_CR) ? tip_pkg::ST_CR
					                                              : tip_pkg::ST_NORMAL;
				end
			end
			tip_pkg::ST_IAC: begin
				cls.tok_valid = 1'b1;
				case (data_byte) inside
					tip_pkg::B_IAC: begin
						cls.kind  = tip_pkg::KIND_TEXT;
						cls.value = data_byte;
					end
					tip_pkg::B_SB: begin
						cls.kind       = tip_pkg::KIND_CMD;
						cls.value      = data_byte;
						cls.next_state = tip_pkg::ST_SUB1;
					end
					tip_pkg::B_DO, tip_pkg::B_DONT, tip_pkg::B_WILL, tip_pkg::B_WONT: begin
						cls.kind       = tip_pkg::KIND_CMD;
						cls.value      = data_byte;
						cls.next_state = tip_pkg::ST_OPT;
					end
					default: begin
						cls.kind = tip_pkg::KIND_END;
					end
				endcase
			end
			tip_pkg::ST_OPT: begin
				cls.tok_valid = 1'b1;
				cls.kind      = tip_pkg::KIND_END;
			end
			tip_pkg::ST_SUB1: begin
				if (data_byte == tip_pkg::B_IAC) begin
					cls.next_state = tip_pkg::ST_SUB2;
				end else begin
					cls.tok_valid  = 1'b1;
					cls.kind       = tip_pkg::KIND_SUBBYTE;
					cls.value      = data_byte;
					cls.next_state = tip_pkg::ST_SUB1;
				end
			end
			tip_pkg::ST_SUB2: begin
				if (data_byte == tip_pkg::B_SE) begin
					cls.tok_valid = 1'b1;
					cls.kind      = tip_pkg::KIND_SUBEND;
				end else begin
					cls.next_state = tip_pkg::ST_SUB1;
				end
			end
			default: begin
				// Normal state, and any code that should never be held.
				if (data_byte == tip_pkg::B_IAC) begin
					cls.next_state = tip_pkg::ST_IAC;
				end else if (data_byte == tip_pkg::B_CR) begin
					cls.next_state = tip_pkg::ST_CR;
				end else begin
					cls.tok_valid = 1'b1;
					cls.value     = data_byte;
				end
			end
		endcase
	end

endmodule

FILE: rtl/telnet_iac_stream_parser.sv
// Top level of the telnet IAC stream parser: input register, per-direction state, result register.
// Depends on tip_pkg and tip_classify.

// The parser takes one byte per cycle on the byte channel while the tok channel does not
// stall, and returns exactly one word per byte on the tok channel, through the input
// register and the result register. Each word tells whether the byte produced a token
// (text, command, subnegotiation byte, subnegotiation end or end marker) and carries the
// byte's direction and chunk-end flag. The client and server streams keep separate parse
// states, so the two directions may be interleaved freely, byte by byte. The sustained rate
// is one byte per clock while tok_ready holds; it is set by the single next-state function
// that reads and writes the state of the byte's direction in the cycle the byte moves from
// the input register to the result register. A new byte is taken while a finished word waits
// in the result register if the input register is empty; the parse state persists across chunks.
module telnet_iac_stream_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_ready,
	input  tip_pkg::byte_t byte_item,
	output logic           tok_valid,
	input  logic           tok_ready,
	output tip_pkg::tok_t  tok
);

	logic            valid_s1;
	tip_pkg::byte_t  item_s1;
	logic            valid_s2;
	tip_pkg::tok_t   tok_s2;
	tip_pkg::state_t state_q [2];

	logic            s2_free;
	logic            advance;
	tip_pkg::cls_t   cls;
	tip_pkg::tok_t   tok_next;

	// The result register can load when it is empty or its word leaves this cycle.
	assign s2_free    = !valid_s2 || tok_ready;
	assign advance    = valid_s1 && s2_free;
	assign byte_ready = !valid_s1 || s2_free;

	tip_classify u_classify (
		.state     (state_q[item_s1.direction]),
		.data_byte (item_s1.data_byte),
		.cls       (cls)
	);

	always_comb begin
		tok_next.token_valid   = cls.tok_valid;
		tok_next.token_kind    = cls.kind;
		tok_next.token_value   = cls.value;
		tok_next.direction_out = item_s1.direction;
		tok_next.chunk_end     = item_s1.last_of_chunk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			state_q[0] <= tip_pkg::ST_NORMAL;
			state_q[1] <= tip_pkg::ST_NORMAL;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			// The state of a direction changes only as its byte is committed.
			if (advance) begin
				state_q[item_s1.direction] <= cls.next_state;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
		if (advance) begin
			tok_s2 <= tok_next;
		end
	end

	assign tok_valid = valid_s2;
	assign tok       = tok_s2;

	// Marker tokens never carry a value.
	a_marker_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok.token_valid &&
		 (tok.token_kind == tip_pkg::KIND_SUBEND || tok.token_kind == tip_pkg::KIND_END))
		|-> (tok.token_value == 8'd0))
		else $error("marker token carries a nonzero value");

	// A word without a token has kind and value cleared.
	a_empty_word_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && !tok.token_valid)
		|-> (tok.token_kind == tip_pkg::KIND_TEXT && tok.token_value == 8'd0))
		else $error("word without token has stale kind or value");

	// A byte held in the input register stays put until it moves on.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost or changed a stalled byte");

	// A finished subnegotiation on direction 0 always returns that direction to the normal state.
	a_subend_to_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cls.tok_valid && cls.kind == tip_pkg::KIND_SUBEND &&
		 !item_s1.direction) |=> (state_q[0] == tip_pkg::ST_NORMAL))
		else $error("subnegotiation end did not restore the normal state");

endmodule
